// ----- hdl/t8eu_pkg.sv -----
// ---------------------------------------------------------------------------
// t8eu_pkg: shared types and constants of the tiny8 execute unit
// Item and result layouts, opcode encoding and the flags byte bit masks.
// ---------------------------------------------------------------------------
package t8eu_pkg;

	// Width of the program counter; the result carries its low byte.
	localparam int PC_WIDTH = 8;

	// Flags byte bit masks.
	localparam logic [7:0] F_CARRY = 8'b0000_0001;
	localparam logic [7:0] F_FIXED = 8'b0000_0010;
	localparam logic [7:0] F_EOF   = 8'b0000_0100;
	localparam logic [7:0] F_ZERO  = 8'b0001_0000;
	localparam logic [7:0] F_OVF   = 8'b0010_0000;

	// Opcodes in instruction bits 15..11. Codes not listed act as NOP.
	typedef enum logic [4:0] {
		OP_NOP  = 5'h00,
		OP_IN   = 5'h01,
		OP_OUT  = 5'h02,
		OP_MOV  = 5'h03,
		OP_MOVC = 5'h04,
		OP_JMP  = 5'h05,
		OP_JZ   = 5'h06,
		OP_JNZ  = 5'h07,
		OP_JC   = 5'h08,
		OP_JO   = 5'h09,
		OP_JFE  = 5'h0A,
		OP_HLT  = 5'h0B,
		OP_INC  = 5'h0C,
		OP_DEC  = 5'h0D,
		OP_ADD  = 5'h0E,
		OP_SUB  = 5'h0F,
		OP_XOR  = 5'h10,
		OP_OR   = 5'h11,
		OP_AND  = 5'h12,
		OP_LSR  = 5'h13,
		OP_LSL  = 5'h14
	} opcode_t;

	// One input item.
	typedef struct packed {
		logic [15:0] instr;
		logic [7:0]  in_byte;
		logic        in_present;
	} item_t;

	// One result item.
	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       in_taken;
		logic [7:0] next_pc;
		logic [7:0] flags_now;
		logic       halted;
	} result_t;

endpackage

// ----- hdl/tiny8_cpu_execute_unit_core.sv -----
// ---------------------------------------------------------------------------
// tiny8_cpu_execute_unit_core: execute unit of a small 8-bit machine
// Runs one 16-bit instruction per transfer against a register file held in
// a synchronous memory, and returns output byte, next PC, flags and halt.
// ---------------------------------------------------------------------------
// Each result passes stage one and the output register before it is offered.
// Throughput: one instruction per cycle while results are not stalled; the
// register file read at transfer and the write-back from stage one are joined
// by a forwarding register, so dependent instructions run back to back.
// Reset clears PC, halt mark, pipeline control and the register valid bits
// (an unwritten register reads as zero); flags reset to 0x02.
module tiny8_cpu_execute_unit_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  t8eu_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output t8eu_pkg::result_t result
);

	// Issue-side decode.
	t8eu_pkg::opcode_t op_in;
	logic              is_alu_in;
	logic [2:0]        a_addr;
	logic [2:0]        b_addr;
	logic              accept;
	logic              advance;

	// Register file memory and valid bits.
	logic [7:0] regs_mem [8];
	logic [7:0] reg_vld_q;

	// Stage one.
	logic              valid_s1;
	t8eu_pkg::opcode_t op_s1;
	logic [2:0]        d_s1;
	logic [7:0]        k_s1;
	logic [7:0]        in_byte_s1;
	logic              in_present_s1;
	logic [7:0]        rd_a_s1;
	logic [7:0]        rd_b_s1;
	logic              vld_a_s1;
	logic              vld_b_s1;
	logic              hit_a_s1;
	logic              hit_b_s1;
	logic [7:0]        fwd_data_q;

	// Architectural state.
	logic [t8eu_pkg::PC_WIDTH-1:0] pc_q;
	logic [7:0]                    flags_q;
	logic                          halt_q;

	// Execute results.
	logic [7:0]                    opa;
	logic [7:0]                    opb;
	logic [8:0]                    sum9;
	logic [7:0]                    alu_r;
	logic                          jump;
	logic signed [7:0]             off_s;
	logic [t8eu_pkg::PC_WIDTH-1:0] pc_nx;
	logic [7:0]                    flags_nx;
	logic                          halt_nx;
	logic                          wr_en;
	logic [7:0]                    wr_data;

	// Output register.
	logic              result_valid_q;
	t8eu_pkg::result_t result_q;
	t8eu_pkg::result_t result_nx;

	// Handshake: stage one advances when the output register is free or drains.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// Read addresses: port A is dest for INC, DEC and two-operand ALU forms,
	// port B is src2 for three-operand ALU forms; both default to src1.
	always_comb begin
		op_in     = t8eu_pkg::opcode_t'(item.instr[15:11]);
		is_alu_in = op_in inside {t8eu_pkg::OP_ADD, t8eu_pkg::OP_SUB, t8eu_pkg::OP_XOR,
			t8eu_pkg::OP_OR, t8eu_pkg::OP_AND};
		if ((op_in inside {t8eu_pkg::OP_INC, t8eu_pkg::OP_DEC}) || (is_alu_in && !item.instr[7])) begin
			a_addr = item.instr[10:8];
		end else begin
			a_addr = item.instr[6:4];
		end
		if (is_alu_in && item.instr[7]) begin
			b_addr = item.instr[2:0];
		end else begin
			b_addr = item.instr[6:4];
		end
	end

	// Register file memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en && advance) begin
			regs_mem[d_s1] <= wr_data;
		end
		if (accept) begin
			rd_a_s1 <= regs_mem[a_addr];
			rd_b_s1 <= regs_mem[b_addr];
		end
	end

	// Stage one payload, including forwarding of a write made in the same cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1         <= op_in;
			d_s1          <= item.instr[10:8];
			k_s1          <= item.instr[7:0];
			in_byte_s1    <= item.in_byte;
			in_present_s1 <= item.in_present;
			vld_a_s1      <= reg_vld_q[a_addr];
			vld_b_s1      <= reg_vld_q[b_addr];
			hit_a_s1      <= wr_en && advance && (d_s1 == a_addr);
			hit_b_s1      <= wr_en && advance && (d_s1 == b_addr);
			fwd_data_q    <= wr_data;
		end
	end

	// Stage one occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Operand selection: forwarded data, then memory, else the reset value.
	always_comb begin
		if (hit_a_s1) begin
			opa = fwd_data_q;
		end else begin
			opa = vld_a_s1 ? rd_a_s1 : 8'h00;
		end
		if (hit_b_s1) begin
			opb = fwd_data_q;
		end else begin
			opb = vld_b_s1 ? rd_b_s1 : 8'h00;
		end
	end

	// Execute: next PC, flags, halt mark, register write and the result.
	always_comb begin
		off_s    = signed'(k_s1);
		sum9     = {1'b0, opa} + {1'b0, opb};
		alu_r    = 8'h00;
		jump     = 1'b0;
		pc_nx    = pc_q + t8eu_pkg::PC_WIDTH'(2);
		flags_nx = flags_q;
		halt_nx  = halt_q;
		wr_en    = 1'b0;
		wr_data  = opa;
		result_nx.out_valid = 1'b0;
		result_nx.out_byte  = 8'h00;
		result_nx.in_taken  = 1'b0;
		if (halt_q) begin
			pc_nx = pc_q;
		end else begin
			case (op_s1)
				t8eu_pkg::OP_IN: begin
					if (in_present_s1) begin
						wr_en              = 1'b1;
						wr_data            = in_byte_s1;
						result_nx.in_taken = 1'b1;
					end else begin
						flags_nx = flags_q | t8eu_pkg::F_EOF;
					end
				end
				t8eu_pkg::OP_OUT: begin
					result_nx.out_valid = 1'b1;
					result_nx.out_byte  = opa;
				end
				t8eu_pkg::OP_MOV: begin
					wr_en = 1'b1;
				end
				t8eu_pkg::OP_MOVC: begin
					wr_en   = 1'b1;
					wr_data = k_s1;
				end
				t8eu_pkg::OP_JMP: jump = 1'b1;
				t8eu_pkg::OP_JZ:  jump = (flags_q & t8eu_pkg::F_ZERO) != 8'h00;
				t8eu_pkg::OP_JNZ: jump = (flags_q & t8eu_pkg::F_ZERO) == 8'h00;
				t8eu_pkg::OP_JC:  jump = (flags_q & t8eu_pkg::F_CARRY) != 8'h00;
				t8eu_pkg::OP_JO:  jump = (flags_q & t8eu_pkg::F_OVF) != 8'h00;
				t8eu_pkg::OP_JFE: jump = (flags_q & t8eu_pkg::F_EOF) != 8'h00;
				t8eu_pkg::OP_HLT: halt_nx = 1'b1;
				t8eu_pkg::OP_INC, t8eu_pkg::OP_DEC, t8eu_pkg::OP_ADD, t8eu_pkg::OP_SUB,
				t8eu_pkg::OP_XOR, t8eu_pkg::OP_OR, t8eu_pkg::OP_AND, t8eu_pkg::OP_LSR,
				t8eu_pkg::OP_LSL: begin
					flags_nx = t8eu_pkg::F_FIXED;
					case (op_s1)
						t8eu_pkg::OP_INC: begin
							alu_r = opa + 8'd1;
							if (opa == 8'hFF) flags_nx = flags_nx | t8eu_pkg::F_CARRY;
							if (opa == 8'h7F) flags_nx = flags_nx | t8eu_pkg::F_OVF;
						end
						t8eu_pkg::OP_DEC: begin
							alu_r = opa - 8'd1;
							if (opa == 8'h00) flags_nx = flags_nx | t8eu_pkg::F_CARRY;
							if (opa == 8'h80) flags_nx = flags_nx | t8eu_pkg::F_OVF;
						end
						t8eu_pkg::OP_ADD: begin
							alu_r = sum9[7:0];
							if (sum9[8]) flags_nx = flags_nx | t8eu_pkg::F_CARRY;
							if (!(opa[7] ^ opb[7]) && (opa[7] ^ alu_r[7])) begin
								flags_nx = flags_nx | t8eu_pkg::F_OVF;
							end
						end
						t8eu_pkg::OP_SUB: begin
							alu_r = opa - opb;
							if (opb > opa) flags_nx = flags_nx | t8eu_pkg::F_CARRY;
							if ((opa[7] ^ opb[7]) && (opa[7] ^ alu_r[7])) begin
								flags_nx = flags_nx | t8eu_pkg::F_OVF;
							end
						end
						t8eu_pkg::OP_XOR: alu_r = opa ^ opb;
						t8eu_pkg::OP_OR:  alu_r = opa | opb;
						t8eu_pkg::OP_AND: alu_r = opa & opb;
						t8eu_pkg::OP_LSR: alu_r = {1'b0, opa[7:1]};
						t8eu_pkg::OP_LSL: alu_r = {opa[6:0], 1'b0};
						default:          alu_r = 8'h00;
					endcase
					if (alu_r == 8'h00) flags_nx = flags_nx | t8eu_pkg::F_ZERO;
					wr_en   = 1'b1;
					wr_data = alu_r;
				end
				default: begin
				end
			endcase
			if (jump) begin
				pc_nx = pc_q + t8eu_pkg::PC_WIDTH'(off_s);
			end
		end
		result_nx.next_pc   = pc_nx[7:0];
		result_nx.flags_now = flags_nx;
		result_nx.halted    = halt_nx;
	end

	// Architectural state and register valid bits, updated as an item retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			flags_q   <= t8eu_pkg::F_FIXED;
			halt_q    <= 1'b0;
			reg_vld_q <= '0;
		end else if (advance) begin
			pc_q    <= pc_nx;
			flags_q <= flags_nx;
			halt_q  <= halt_nx;
			if (wr_en) begin
				reg_vld_q[d_s1] <= 1'b1;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// Once halted, the machine stays halted.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q) else $error("halt mark cleared");

	// A halted machine holds its PC and flags.
	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(halt_q && advance) |=> (pc_q == $past(pc_q)) && (flags_q == $past(flags_q)))
		else $error("state changed after halt");

	// No register write-back without a retiring, running instruction.
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && advance |-> !halt_q && valid_s1) else $error("stray register write");

	// The input side stalls only behind a full, stalled output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid_q && result_stall)
		else $error("input stalled without cause");

	// The fixed flag bit is always set.
	a_fixed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(flags_q & t8eu_pkg::F_FIXED) != 8'h00) else $error("fixed flag lost");
`endif

endmodule

// ----- verif/t8eu_exec_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// t8eu_exec_checker: result checker for the tiny8 execute unit
// Watches both channels of the core, runs its own model of the machine for
// every instruction transfer and compares each result transfer, field by
// field, with the oldest predicted result.
// ---------------------------------------------------------------------------
module t8eu_exec_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  t8eu_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  t8eu_pkg::result_t result,
	output int                n_fail,
	output int                n_pending
);

	// Machine state as the core should hold it.
	logic [7:0]                    gpr [8];
	logic [7:0]                    flags_q;
	logic [t8eu_pkg::PC_WIDTH-1:0] pc_q;
	logic                          halted_q;

	// Predicted results, oldest first.
	t8eu_pkg::result_t exp_results [$];
	int                errors;
	int                n_results;

	// Return the machine to its state after reset.
	function automatic void clear_machine();
		for (int i = 0; i < 8; i++) begin
			gpr[i] = 8'h00;
		end
		flags_q  = t8eu_pkg::F_FIXED;
		pc_q     = '0;
		halted_q = 1'b0;
	endfunction

	// Execute one instruction on the model and return the result it gives.
	function automatic t8eu_pkg::result_t exec_instr(input t8eu_pkg::item_t it);
		t8eu_pkg::result_t             res;
		t8eu_pkg::opcode_t             op;
		logic [2:0]                    rd;
		logic [2:0]                    rs1;
		logic [2:0]                    rs2;
		logic                          mode;
		logic [7:0]                    k;
		logic [7:0]                    a;
		logic [7:0]                    b;
		logic [7:0]                    v;
		logic [8:0]                    wide;
		logic [t8eu_pkg::PC_WIDTH-1:0] npc;
		logic                          take;
		logic                          alu;

		op   = t8eu_pkg::opcode_t'(it.instr[15:11]);
		rd   = it.instr[10:8];
		mode = it.instr[7];
		rs1  = it.instr[6:4];
		rs2  = it.instr[2:0];
		k    = it.instr[7:0];
		res  = '0;
		take = 1'b0;
		alu  = 1'b0;
		v    = 8'h00;
		npc  = pc_q + t8eu_pkg::PC_WIDTH'(2);

		if (halted_q) begin
			// A halted machine only reports its held state.
			npc = pc_q;
		end else begin
			case (op)
				t8eu_pkg::OP_IN: begin
					if (it.in_present) begin
						gpr[rd]      = it.in_byte;
						res.in_taken = 1'b1;
					end else begin
						flags_q = flags_q | t8eu_pkg::F_EOF;
					end
				end
				t8eu_pkg::OP_OUT: begin
					res.out_valid = 1'b1;
					res.out_byte  = gpr[rs1];
				end
				t8eu_pkg::OP_MOV:  gpr[rd] = gpr[rs1];
				t8eu_pkg::OP_MOVC: gpr[rd] = k;
				t8eu_pkg::OP_JMP:  take = 1'b1;
				t8eu_pkg::OP_JZ:   take = (flags_q & t8eu_pkg::F_ZERO) != 8'h00;
				t8eu_pkg::OP_JNZ:  take = (flags_q & t8eu_pkg::F_ZERO) == 8'h00;
				t8eu_pkg::OP_JC:   take = (flags_q & t8eu_pkg::F_CARRY) != 8'h00;
				t8eu_pkg::OP_JO:   take = (flags_q & t8eu_pkg::F_OVF) != 8'h00;
				t8eu_pkg::OP_JFE:  take = (flags_q & t8eu_pkg::F_EOF) != 8'h00;
				t8eu_pkg::OP_HLT:  halted_q = 1'b1;
				t8eu_pkg::OP_INC: begin
					a       = gpr[rd];
					flags_q = flags_q & t8eu_pkg::F_FIXED;
					if (a == 8'hFF) flags_q = flags_q | t8eu_pkg::F_CARRY;
					if (a == 8'h7F) flags_q = flags_q | t8eu_pkg::F_OVF;
					v   = a + 8'h01;
					alu = 1'b1;
				end
				t8eu_pkg::OP_DEC: begin
					a       = gpr[rd];
					flags_q = flags_q & t8eu_pkg::F_FIXED;
					if (a == 8'h00) flags_q = flags_q | t8eu_pkg::F_CARRY;
					if (a == 8'h80) flags_q = flags_q | t8eu_pkg::F_OVF;
					v   = a - 8'h01;
					alu = 1'b1;
				end
				t8eu_pkg::OP_ADD, t8eu_pkg::OP_SUB, t8eu_pkg::OP_XOR,
				t8eu_pkg::OP_OR, t8eu_pkg::OP_AND: begin
					// Mode 1 takes both sources from src1/src2, mode 0 uses dest and src1.
					a       = mode ? gpr[rs1] : gpr[rd];
					b       = mode ? gpr[rs2] : gpr[rs1];
					flags_q = flags_q & t8eu_pkg::F_FIXED;
					alu     = 1'b1;
					case (op)
						t8eu_pkg::OP_ADD: begin
							wide = {1'b0, a} + {1'b0, b};
							v    = wide[7:0];
							if (wide[8]) flags_q = flags_q | t8eu_pkg::F_CARRY;
							if (a[7] == b[7] && v[7] != a[7]) flags_q = flags_q | t8eu_pkg::F_OVF;
						end
						t8eu_pkg::OP_SUB: begin
							v = a - b;
							if (b > a) flags_q = flags_q | t8eu_pkg::F_CARRY;
							if (a[7] != b[7] && v[7] != a[7]) flags_q = flags_q | t8eu_pkg::F_OVF;
						end
						t8eu_pkg::OP_XOR: v = a ^ b;
						t8eu_pkg::OP_OR:  v = a | b;
						default:          v = a & b;
					endcase
				end
				t8eu_pkg::OP_LSR, t8eu_pkg::OP_LSL: begin
					a       = gpr[rs1];
					flags_q = flags_q & t8eu_pkg::F_FIXED;
					v       = (op == t8eu_pkg::OP_LSR) ? (a >> 1) : (a << 1);
					alu     = 1'b1;
				end
				default: ;
			endcase

			// Flag-updating operations write dest and report a zero result.
			if (alu) begin
				gpr[rd] = v;
				if (v == 8'h00) flags_q = flags_q | t8eu_pkg::F_ZERO;
			end

			// Taken jumps are relative to the jump's own address.
			if (take) npc = pc_q + t8eu_pkg::PC_WIDTH'($signed(k));
			pc_q = npc;
		end

		res.next_pc   = npc[7:0];
		res.flags_now = flags_q;
		res.halted    = halted_q;
		return res;
	endfunction

	// Compare one field and report the early mismatches.
	task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch in result %0d, %s: expected %h, got %h",
					n_results, fname, want, got);
			end
		end
	endtask

	// Channel monitor: results are checked before the same edge's item is predicted.
	always @(posedge clk or negedge arst_n) begin : watch
		t8eu_pkg::result_t want;

		if (!arst_n) begin
			clear_machine();
			exp_results.delete();
			errors    = 0;
			n_results = 0;
		end else begin
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				if (exp_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected result %0d: %p", n_results, result);
					end
				end else begin
					want = exp_results.pop_front();
					check_field("out_valid", 8'(want.out_valid), 8'(result.out_valid));
					check_field("out_byte", want.out_byte, result.out_byte);
					check_field("in_taken", 8'(want.in_taken), 8'(result.in_taken));
					check_field("next_pc", want.next_pc, result.next_pc);
					check_field("flags_now", want.flags_now, result.flags_now);
					check_field("halted", 8'(want.halted), 8'(result.halted));
				end
				n_results++;
			end
			if (item_valid === 1'b1 && item_stall === 1'b0) begin
				exp_results.push_back(exec_instr(item));
			end
		end
		n_fail    <= errors;
		n_pending <= exp_results.size();
	end

endmodule

// ----- verif/tiny8_cpu_execute_unit_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tiny8_cpu_execute_unit_core_tb: testbench of the tiny8 execute unit
// Sends a directed instruction sequence, then random instructions in bursts
// while the result side stalls on its own pattern, and ends with a halt and
// a few instructions after it. A separate checker predicts and compares.
// ---------------------------------------------------------------------------
module tiny8_cpu_execute_unit_core_tb;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	t8eu_pkg::item_t   item;
	logic              result_valid;
	logic              result_stall;
	t8eu_pkg::result_t result;
	int                n_fail;
	int                n_pending;

	// Instruction transfers so far and transfers left in the current burst.
	int      n_sent = 0;
	int      burst_left = 0;

	tiny8_cpu_execute_unit_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	t8eu_exec_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.n_fail       (n_fail),
		.n_pending    (n_pending)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Register-register form: dest, mode, src1, src2.
	function automatic t8eu_pkg::item_t op_rr(input t8eu_pkg::opcode_t op, input int d,
			input bit m, input int s1, input int s2);
		t8eu_pkg::item_t it;
		it.instr      = {op, 3'(d), m, 3'(s1), 1'b0, 3'(s2)};
		it.in_byte    = 8'($urandom);
		it.in_present = 1'b1;
		return it;
	endfunction

	// Constant form: dest and an 8-bit constant or jump offset.
	function automatic t8eu_pkg::item_t op_k(input t8eu_pkg::opcode_t op, input int d,
			input logic [7:0] k);
		t8eu_pkg::item_t it;
		it.instr      = {op, 3'(d), k};
		it.in_byte    = 8'($urandom);
		it.in_present = 1'b1;
		return it;
	endfunction

	// Random instruction that never halts; some undefined opcodes, and MOVC
	// often loads a boundary value so that carries and overflows show up.
	function automatic t8eu_pkg::item_t rand_item();
		t8eu_pkg::item_t it;
		logic [4:0]      op;

		it.instr = 16'($urandom);
		if ($urandom_range(0, 99) < 10) begin
			op = $urandom_range(0, 1) ? 5'($urandom_range(21, 31)) : 5'(t8eu_pkg::OP_NOP);
		end else begin
			do op = 5'($urandom_range(1, 20)); while (op == t8eu_pkg::OP_HLT);
		end
		it.instr[15:11] = op;
		if (op == t8eu_pkg::OP_MOVC && $urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 3))
				0:       it.instr[7:0] = 8'h00;
				1:       it.instr[7:0] = 8'h7F;
				2:       it.instr[7:0] = 8'h80;
				default: it.instr[7:0] = 8'hFF;
			endcase
		end
		it.in_byte    = 8'($urandom);
		it.in_present = ($urandom_range(0, 4) != 0);
		return it;
	endfunction

	// Offer one instruction until it is transferred, then maybe pause.
	task automatic send_item(input t8eu_pkg::item_t it);
		int gap;

		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 15);
		end
	endtask

	// Result side: stall density changes per segment, with one long hold-off.
	initial begin : result_side
		int  pct;
		bit  held;

		held = 1'b0;
		result_stall <= 1'b0;
		forever begin
			case ($urandom_range(0, 4))
				0, 1:    pct = 0;
				2:       pct = 30;
				3:       pct = 60;
				default: pct = 90;
			endcase
			repeat ($urandom_range(20, 120)) begin
				@(posedge clk);
				if (!held && n_sent >= 300) begin
					held = 1'b1;
					result_stall <= 1'b1;
					repeat (200) @(posedge clk);
				end
				result_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		t8eu_pkg::item_t it;

		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: all-zero word, input present and exhausted.
		send_item('0);
		it = op_k(t8eu_pkg::OP_IN, 0, 8'h00);
		it.in_byte = 8'hFF;
		send_item(it);
		it = op_k(t8eu_pkg::OP_IN, 1, 8'hFF);
		it.in_present = 1'b0;
		send_item(it);
		send_item(op_k(t8eu_pkg::OP_JFE, 0, 8'h06));

		// Increment and decrement across the signed and unsigned limits.
		send_item(op_k(t8eu_pkg::OP_MOVC, 2, 8'h7F));
		send_item(op_k(t8eu_pkg::OP_INC, 2, 8'h00));
		send_item(op_k(t8eu_pkg::OP_JO, 0, 8'hFC));
		send_item(op_k(t8eu_pkg::OP_MOVC, 3, 8'hFF));
		send_item(op_k(t8eu_pkg::OP_INC, 3, 8'h00));
		send_item(op_k(t8eu_pkg::OP_JZ, 0, 8'h7F));
		send_item(op_k(t8eu_pkg::OP_JC, 0, 8'h80));
		send_item(op_k(t8eu_pkg::OP_DEC, 3, 8'h00));
		send_item(op_k(t8eu_pkg::OP_DEC, 2, 8'h00));
		send_item(op_k(t8eu_pkg::OP_JNZ, 0, 8'h02));

		// Both ALU modes, carry and overflow on add and subtract.
		send_item(op_rr(t8eu_pkg::OP_ADD, 3, 1'b0, 0, 0));
		send_item(op_k(t8eu_pkg::OP_MOVC, 6, 8'h80));
		send_item(op_rr(t8eu_pkg::OP_ADD, 7, 1'b1, 6, 6));
		send_item(op_rr(t8eu_pkg::OP_SUB, 5, 1'b1, 7, 0));
		send_item(op_rr(t8eu_pkg::OP_SUB, 2, 1'b0, 6, 0));
		send_item(op_rr(t8eu_pkg::OP_XOR, 4, 1'b1, 0, 0));
		send_item(op_rr(t8eu_pkg::OP_OR, 4, 1'b0, 2, 0));
		send_item(op_rr(t8eu_pkg::OP_AND, 4, 1'b1, 2, 6));
		send_item(op_rr(t8eu_pkg::OP_LSR, 5, 1'b0, 0, 0));
		send_item(op_rr(t8eu_pkg::OP_LSL, 5, 1'b0, 0, 0));
		send_item(op_rr(t8eu_pkg::OP_MOV, 1, 1'b0, 0, 0));
		send_item(op_k(t8eu_pkg::OP_OUT, 7, 8'hFF));
		send_item(op_k(t8eu_pkg::OP_JMP, 0, 8'h80));
		send_item(op_k(t8eu_pkg::OP_JMP, 0, 8'h7F));
		it = rand_item();
		it.instr = 16'hFFFF;
		send_item(it);

		// Random part.
		repeat (800) send_item(rand_item());

		// Halt, then a few instructions that must leave the machine as it is.
		send_item(op_k(t8eu_pkg::OP_HLT, 7, 8'hFF));
		repeat (6) send_item(rand_item());
		item_valid <= 1'b0;

		// Let the count see the last transfer, drain, then leave room for any
		// stray result.
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (n_fail == 0 && n_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin : watchdog
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
